// ===== rtl/tpag_pkg.sv =====
// Package for the tensor pad address generator.
// Shared widths, config register codes and reset values, the item struct and
// the register field extraction function. No dependencies.
package tpag_pkg;

  localparam int unsigned IDX_W     = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_EXT  = 2'd0,
    CFG_OUT_EXT = 2'd1,
    CFG_LO_PAD  = 2'd2,
    CFG_INT_PAD = 2'd3
  } tpag_cfg_e;

  localparam logic [CFG_W-1:0] IN_EXT_RST  = 64'h0001_0001_0001_0001;
  localparam logic [CFG_W-1:0] OUT_EXT_RST = 64'h0001_0001_0001_0001;
  localparam logic [CFG_W-1:0] LO_PAD_RST  = 64'h0;
  localparam logic [CFG_W-1:0] INT_PAD_RST = 64'h0;

  // Per-item state as it moves down the dimension pipeline.
  typedef struct packed {
    logic [IDX_W-1:0] rest;
    logic [IDX_W-1:0] acc;
    logic [IDX_W-1:0] stride;
    logic             hit;
    logic             past_end;
  } tpag_item_t;

  // Field of eb bits at bit pos; zero where it lies beyond the register.
  function automatic logic [CFG_W-1:0] field_of(input logic [CFG_W-1:0] r,
                                                input int unsigned pos,
                                                input int unsigned eb);
    logic [CFG_W-1:0] mask;
    mask = (eb >= CFG_W) ? '1 : ((CFG_W'(1) << eb) - CFG_W'(1));
    if (pos >= CFG_W) begin
      return '0;
    end
    return (r >> pos) & mask;
  endfunction

endpackage

// ===== rtl/tpag_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Divisor is a static input (held from config). Uses no package items.
module tpag_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] pay_o
);

  logic [NW-1:0] v_q;
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [PW-1:0] pay_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [NW-1:0] num_d;
    logic [DW-1:0] rem_d;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign pay_in = pay_q[s-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign ge    = trial >= {1'b0, den_i};
    assign diff  = trial - {1'b0, den_i};
    assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign num_d = {num_in[NW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_d;
        rem_q[s] <= rem_d;
        pay_q[s] <= pay_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = num_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign pay_o   = pay_q[NW-1];

endmodule

// ===== rtl/tpag_cnt.sv =====
// Output element count (saturated) and past-end check, one dimension a stage.
// Depends on tpag_pkg.
module tpag_cnt #(
  parameter int unsigned MAX_RANK = 4,
  parameter int unsigned EB       = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [tpag_pkg::IDX_W-1:0]    idx_i,
  input  logic [MAX_RANK-1:0][EB-1:0]   oe_i,
  output logic                          valid_o,
  output tpag_pkg::tpag_item_t          item_o
);

  localparam int unsigned TW = tpag_pkg::IDX_W + 1;
  localparam int unsigned MW = TW + EB;
  localparam logic [TW-1:0] CAP = TW'(1) << tpag_pkg::IDX_W;

  logic [MAX_RANK-1:0]          v_q;
  logic [TW-1:0]                tot_q [MAX_RANK];
  logic [tpag_pkg::IDX_W-1:0]   idx_q [MAX_RANK];
  logic                         vo_q;
  tpag_pkg::tpag_item_t         item_q;
  tpag_pkg::tpag_item_t         item_d;

  for (genvar s = 0; s < MAX_RANK; s++) begin : g_stage
    logic                       v_in;
    logic [TW-1:0]              tot_in;
    logic [tpag_pkg::IDX_W-1:0] idx_in;
    logic [MW-1:0]              prod;
    logic [TW-1:0]              tot_d;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign tot_in = TW'(1);
      assign idx_in = idx_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign tot_in = tot_q[s-1];
      assign idx_in = idx_q[s-1];
    end

    assign prod  = MW'(tot_in) * MW'(oe_i[s]);
    assign tot_d = (prod > MW'(CAP)) ? CAP : prod[TW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tot_q[s] <= tot_d;
        idx_q[s] <= idx_in;
      end
    end
  end

  always_comb begin
    item_d          = '0;
    item_d.rest     = idx_q[MAX_RANK-1];
    item_d.stride   = tpag_pkg::IDX_W'(1);
    item_d.hit      = 1'b1;
    item_d.past_end = {1'b0, idx_q[MAX_RANK-1]} >= tot_q[MAX_RANK-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[MAX_RANK-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = vo_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/tpag_dim.sv =====
// One dimension of the index walk: coordinate split, pad check, dilation
// divide and row-major accumulate. Depends on tpag_pkg and tpag_div.
module tpag_dim #(
  parameter int unsigned EB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tpag_pkg::tpag_item_t item_i,
  input  logic [EB-1:0]        oe_i,
  input  logic [EB-1:0]        ie_i,
  input  logic [EB-1:0]        lo_i,
  input  logic [EB-1:0]        ip_i,
  output logic                 valid_o,
  output tpag_pkg::tpag_item_t item_o
);

  localparam int unsigned IW = tpag_pkg::IDX_W;
  localparam int unsigned PW = $bits(tpag_pkg::tpag_item_t);
  localparam int unsigned MW = IW + EB;

  logic [EB:0] sp;
  assign sp = {1'b0, ip_i} + (EB+1)'(1);

  // coordinate = rest mod extent, rest = rest / extent
  logic                 v1;
  logic [IW-1:0]        quo1;
  logic [EB-1:0]        rem1;
  logic [PW-1:0]        pay1;
  tpag_pkg::tpag_item_t it1;

  tpag_div #(.NW(IW), .DW(EB), .PW(PW)) u_div_ext (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .num_i   (item_i.rest),
    .den_i   (oe_i),
    .pay_i   (item_i),
    .valid_o (v1),
    .quo_o   (quo1),
    .rem_o   (rem1),
    .pay_o   (pay1)
  );
  assign it1 = pay1;

  logic                 vb_q;
  tpag_pkg::tpag_item_t itb_q;
  tpag_pkg::tpag_item_t itb_d;
  logic [EB-1:0]        db_q;

  always_comb begin
    itb_d      = it1;
    itb_d.rest = quo1;
    itb_d.hit  = it1.hit & (rem1 >= lo_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itb_q <= itb_d;
      db_q  <= rem1 - lo_i;
    end
  end

  // input coordinate = (coord - low pad) / (interior pad + 1)
  logic                 v2;
  logic [EB-1:0]        quo2;
  logic [EB:0]          rem2;
  logic [PW-1:0]        pay2;
  tpag_pkg::tpag_item_t it2;

  tpag_div #(.NW(EB), .DW(EB+1), .PW(PW)) u_div_sp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vb_q),
    .num_i   (db_q),
    .den_i   (sp),
    .pay_i   (itb_q),
    .valid_o (v2),
    .quo_o   (quo2),
    .rem_o   (rem2),
    .pay_o   (pay2)
  );
  assign it2 = pay2;

  logic                 vc_q;
  tpag_pkg::tpag_item_t itc_q;
  tpag_pkg::tpag_item_t itc_d;
  logic [IW-1:0]        prodc_q;
  logic [MW-1:0]        prod;
  logic [MW-1:0]        str_n;

  assign prod  = MW'(it2.stride) * MW'(quo2);
  assign str_n = MW'(it2.stride) * MW'(ie_i);

  always_comb begin
    itc_d        = it2;
    itc_d.hit    = it2.hit & (rem2 == '0) & (quo2 < ie_i);
    itc_d.stride = str_n[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itc_q   <= itc_d;
      prodc_q <= prod[IW-1:0];
    end
  end

  logic                 vd_q;
  tpag_pkg::tpag_item_t itd_q;
  tpag_pkg::tpag_item_t itd_d;

  always_comb begin
    itd_d     = itc_q;
    itd_d.acc = itc_q.acc + prodc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itd_q <= itd_d;
    end
  end

  assign valid_o = vd_q;
  assign item_o  = itd_q;

endmodule

// ===== rtl/tensor_pad_address_generator_unit.sv =====
// Top level of the tensor pad address generator: config registers, count
// stage, one pipeline section per dimension and the output register.
// Depends on tpag_pkg, tpag_cnt, tpag_dim (and tpag_div below it).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid_i/in_stall_o| output_index_i
//   out      | out_valid_o/out_stall_i | from_input_o input_index_o past_end_o
//   cfg      | cfg_we_i             | cfg_index_i cfg_data_i
//
// One item per cycle unless out_stall_i holds the pipeline.
// All stages advance together; out_stall_i with a valid result holds the
// whole pipeline, and in_stall_o is raised for that cycle.
// Reset clears all valid bits and loads the config reset values.
module tensor_pad_address_generator_unit #(
  parameter int unsigned MAX_RANK    = 4,
  parameter int unsigned EXTENT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tpag_pkg::IDX_W-1:0]     output_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           from_input_o,
  output logic [tpag_pkg::IDX_W-1:0]     input_index_o,
  output logic                           past_end_o,
  input  logic                           cfg_we_i,
  input  logic [tpag_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tpag_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned EB = EXTENT_BITS;

  logic [tpag_pkg::CFG_W-1:0] in_ext_q, out_ext_q, lo_pad_q, int_pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ext_q  <= tpag_pkg::IN_EXT_RST;
      out_ext_q <= tpag_pkg::OUT_EXT_RST;
      lo_pad_q  <= tpag_pkg::LO_PAD_RST;
      int_pad_q <= tpag_pkg::INT_PAD_RST;
    end else if (cfg_we_i) begin
      unique case (tpag_pkg::tpag_cfg_e'(cfg_index_i))
        tpag_pkg::CFG_IN_EXT:  in_ext_q  <= cfg_data_i;
        tpag_pkg::CFG_OUT_EXT: out_ext_q <= cfg_data_i;
        tpag_pkg::CFG_LO_PAD:  lo_pad_q  <= cfg_data_i;
        tpag_pkg::CFG_INT_PAD: int_pad_q <= cfg_data_i;
      endcase
    end
  end

  logic [MAX_RANK-1:0][EB-1:0] oe_f, ie_f, lo_f, ip_f;

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_field
    localparam int unsigned POS = (MAX_RANK - 1 - k) * EB;
    assign oe_f[k] = EB'(tpag_pkg::field_of(out_ext_q, POS, EB));
    assign ie_f[k] = EB'(tpag_pkg::field_of(in_ext_q, POS, EB));
    assign lo_f[k] = EB'(tpag_pkg::field_of(lo_pad_q, POS, EB));
    assign ip_f[k] = EB'(tpag_pkg::field_of(int_pad_q, POS, EB));
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic                 v_chain  [MAX_RANK+1];
  tpag_pkg::tpag_item_t it_chain [MAX_RANK+1];

  tpag_cnt #(.MAX_RANK(MAX_RANK), .EB(EB)) u_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .idx_i   (output_index_i),
    .oe_i    (oe_f),
    .valid_o (v_chain[0]),
    .item_o  (it_chain[0])
  );

  // last dimension first
  for (genvar j = 0; j < MAX_RANK; j++) begin : g_dim
    localparam int unsigned K = MAX_RANK - 1 - j;
    tpag_dim #(.EB(EB)) u_dim (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_chain[j]),
      .item_i  (it_chain[j]),
      .oe_i    (oe_f[K]),
      .ie_i    (ie_f[K]),
      .lo_i    (lo_f[K]),
      .ip_i    (ip_f[K]),
      .valid_o (v_chain[j+1]),
      .item_o  (it_chain[j+1])
    );
  end

  tpag_pkg::tpag_item_t  last;
  logic                  from_input_q, past_end_q;
  logic [tpag_pkg::IDX_W-1:0] input_index_q;
  logic                  hit_d;

  assign last  = it_chain[MAX_RANK];
  assign hit_d = last.hit & !last.past_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_chain[MAX_RANK];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      from_input_q  <= hit_d;
      input_index_q <= hit_d ? last.acc : '0;
      past_end_q    <= last.past_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign from_input_o  = from_input_q;
  assign input_index_o = input_index_q;
  assign past_end_o    = past_end_q;

  a_past_end_no_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && past_end_o |-> !from_input_o)
    else $error("past-end item flagged as copy");

  a_pad_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !from_input_o |-> input_index_o == '0)
    else $error("pad item with nonzero input index");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

// ===== dv/tb_tensor_pad_address_generator_unit.sv =====
// Testbench for tensor_pad_address_generator_unit: directed and random flat output
// indices under several pad configurations, checked against an in-bench address model.
// Depends on tpag_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_tensor_pad_address_generator_unit;
  import tpag_pkg::*;

  localparam int unsigned RANK     = 4;
  localparam int unsigned EXT_W    = 16;
  localparam int unsigned LATENCY  = 210;
  localparam longint      MAX_CYC  = 1500000;

  typedef struct packed {
    logic             from_input;
    logic [IDX_W-1:0] input_index;
    logic             past_end;
  } addr_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [IDX_W-1:0]     output_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 from_input_o;
  logic [IDX_W-1:0]     input_index_o;
  logic                 past_end_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  logic [CFG_W-1:0] in_ext, out_ext, lo_pad, int_pad;
  addr_res_t        expected_q[$];
  int unsigned      n_err, n_items, n_hits, n_pad, n_past;
  longint           cyc;
  int unsigned      stall_mode;

  tensor_pad_address_generator_unit #(.MAX_RANK(RANK), .EXTENT_BITS(EXT_W)) u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("tb_tensor_pad_address_generator_unit: done, errors");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] dim_of(logic [CFG_W-1:0] r, int unsigned k);
    return (r >> ((RANK - 1 - k) * EXT_W)) & 64'hFFFF;
  endfunction

  function automatic addr_res_t map_index(logic [IDX_W-1:0] oidx);
    addr_res_t   res;
    logic [63:0] count, e, rest, c, d, q, sp, acc, stride;
    logic        hit;
    res = '0;
    count = 1;
    for (int k = 0; k < RANK; k++) begin
      e = dim_of(out_ext, k);
      if (e == 0) begin
        count = 0;
        break;
      end
      if (count > 64'hFFFF_FFFF_FFFF_FFFF / e) count = 64'hFFFF_FFFF_FFFF_FFFF;
      else count = count * e;
    end
    if (64'(oidx) >= count) begin
      res.past_end = 1'b1;
      return res;
    end
    rest = oidx;
    acc = 0;
    stride = 1;
    hit = 1'b1;
    for (int k = RANK - 1; k >= 0; k--) begin
      e = dim_of(out_ext, k);
      c = rest % e;
      rest = rest / e;
      if (c < dim_of(lo_pad, k)) begin
        hit = 1'b0;
      end else begin
        sp = dim_of(int_pad, k) + 1;
        d = c - dim_of(lo_pad, k);
        q = d / sp;
        if ((d % sp) != 0 || q >= dim_of(in_ext, k)) hit = 1'b0;
        else acc = acc + q * stride;
      end
      stride = stride * dim_of(in_ext, k);
    end
    res.from_input = hit;
    res.input_index = hit ? acc[31:0] : '0;
    return res;
  endfunction

  // receiver stall pattern
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk_i) begin
    addr_res_t got, exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{from_input_o, input_index_o, past_end_o};
      if (expected_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.from_input !== exp_r.from_input)
          $display("%0t: from_input exp %0d got %0d", $time, exp_r.from_input, got.from_input);
        if (got.input_index !== exp_r.input_index)
          $display("%0t: input_index exp %0h got %0h", $time, exp_r.input_index,
                   got.input_index);
        if (got.past_end !== exp_r.past_end)
          $display("%0t: past_end exp %0d got %0d", $time, exp_r.past_end, got.past_end);
        if (got !== exp_r) n_err++;
      end
    end
  end

  task automatic send_index(logic [IDX_W-1:0] oidx);
    addr_res_t r;
    in_valid_i <= 1'b1;
    output_index_i <= oidx;
    do @(posedge clk_i); while (in_stall_o);
    r = map_index(oidx);
    expected_q.push_back(r);
    n_items++;
    if (r.past_end) n_past++;
    else if (r.from_input) n_hits++;
    else n_pad++;
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(tpag_cfg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_IN_EXT:  in_ext = val;
      CFG_OUT_EXT: out_ext = val;
      CFG_LO_PAD:  lo_pad = val;
      default:     int_pad = val;
    endcase
  endtask

  task automatic set_shape(logic [CFG_W-1:0] ie, logic [CFG_W-1:0] oe,
                           logic [CFG_W-1:0] lp, logic [CFG_W-1:0] ip);
    drain();
    write_reg(CFG_IN_EXT, ie);
    write_reg(CFG_OUT_EXT, oe);
    write_reg(CFG_LO_PAD, lp);
    write_reg(CFG_INT_PAD, ip);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] out_count();
    logic [63:0] n;
    n = 1;
    for (int k = 0; k < RANK; k++) n = n * dim_of(out_ext, k);
    return n;
  endfunction

  // random bursts of indices, mostly inside the tensor
  task automatic send_burst_run(int unsigned n);
    logic [63:0] lim;
    logic [31:0] v;
    int unsigned burst;
    lim = out_count();
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender();
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 9) == 0 || lim == 0 || lim > 64'hFFFF_FFFF) v = $urandom;
      else v = 32'($urandom_range(0, 32'(lim - 1) + ($urandom_range(0, 1) ? 2 : 0)));
      send_index(v);
    end
  endtask

  task automatic test_reset_values();
    in_ext = IN_EXT_RST;
    out_ext = OUT_EXT_RST;
    lo_pad = LO_PAD_RST;
    int_pad = INT_PAD_RST;
    send_index(0);
    send_index(1);
    send_index('1);
  endtask

  task automatic test_directed();
    // 2x3 input, lo pad 1, interior 1 on the last two dims -> 5x7 output
    set_shape(64'h0001_0001_0002_0003, 64'h0001_0001_0005_0007,
              64'h0000_0000_0001_0001, 64'h0000_0000_0001_0001);
    for (int i = 0; i < 12; i++) send_index(i * 3);
    send_index(34);
    send_index(35);
    send_index(32'h8000_0000);
    // zero output extent: all past the end
    set_shape(64'h0001_0001_0002_0003, 64'h0001_0000_0005_0007, '0, '0);
    send_index(0);
    // zero input extent: all pad
    set_shape(64'h0001_0001_0000_0003, 64'h0001_0001_0004_0003, '0, '0);
    send_index(1);
    send_index(11);
    // saturating count, wrapped input index
    set_shape('1, '1, '1, '0);
    send_index('1);
    send_index(32'h5555_AAAA);
    set_shape('1, '1, '0, '0);
    send_index('1);
    send_index(32'hAAAA_5555);
  endtask

  task automatic test_random_shapes();
    logic [CFG_W-1:0] ie, oe, lp, ip;
    for (int s = 0; s < 14; s++) begin
      ie = '0; oe = '0; lp = '0; ip = '0;
      for (int k = 0; k < RANK; k++) begin
        logic [15:0] a, l, p, o;
        a = $urandom_range(0, 4);
        l = $urandom_range(0, 2);
        p = $urandom_range(0, 2);
        o = (a == 0 ? 1 : a + (a - 1) * p) + l + $urandom_range(0, 2);
        if ($urandom_range(0, 15) == 0) o = 0;
        if (k < 1 && $urandom_range(0, 1)) begin
          a = 1; o = 1; l = 0; p = 0;
        end
        ie = (ie << 16) | a;
        oe = (oe << 16) | o;
        lp = (lp << 16) | l;
        ip = (ip << 16) | p;
      end
      stall_mode = s % 3;
      set_shape(ie, oe, lp, ip);
      send_burst_run(50);
    end
    stall_mode = 2;
    set_shape({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom});
    send_burst_run(30);
  endtask

  initial begin
    n_err = 0; n_items = 0; n_hits = 0; n_pad = 0; n_past = 0;
    stall_mode = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_random_shapes();
    drain();
    $display("covered %0d indices over 21 pad shapes: %0d copies, %0d pad, %0d past end",
             n_items, n_hits, n_pad, n_past);
    if (n_err == 0) begin
      $display("tb_tensor_pad_address_generator_unit: done, clean");
    end else begin
      $display("tb_tensor_pad_address_generator_unit: done, errors");
    end
    $finish;
  end

endmodule
